[rtl/svt_pkg.sv]
`timescale 1ns / 1ps
// Shared types and constants of the sorted value table.
// Depends on nothing; sorted_value_table_unit imports it.
package svt_pkg;

    localparam int CAPACITY = 32;
    localparam int VAL_W    = 32;
    localparam int OCC_W    = 6;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int ADDR_W   = $clog2(CAPACITY);

    typedef logic [CNT_W-1:0]  cnt_t;
    typedef logic [ADDR_W-1:0] addr_t;
    typedef logic [OCC_W-1:0]  occ_t;

    typedef enum logic [1:0] {
        FUNC_INSERT = 2'd0,
        FUNC_SEARCH = 2'd1,
        FUNC_DELETE = 2'd2,
        FUNC_LIST   = 2'd3
    } func_t;

    typedef enum logic [1:0] {
        STATUS_DONE      = 2'd0,
        STATUS_NOT_FOUND = 2'd1,
        STATUS_FULL      = 2'd2,
        STATUS_EMPTY     = 2'd3
    } status_t;

    typedef struct packed {
        func_t                   func;
        logic signed [VAL_W-1:0] value;
    } cmd_t;

    typedef struct packed {
        status_t                 status;
        logic signed [VAL_W-1:0] value_out;
        logic                    last;
        occ_t                    occupancy;
    } rsp_t;

endpackage

[rtl/svt_ram.sv]
`timescale 1ns / 1ps
// Generic single-clock RAM: one write port, one read port, registered read.
// Depends on nothing.
module svt_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

[rtl/sorted_value_table_unit.sv]
`timescale 1ns / 1ps
// Sorted value table: top level with the sequencer around one value RAM.
// Depends on svt_pkg and svt_ram.
//
//  channel   | signals              | transfer
//  ----------+----------------------+-----------------------------------------
//  command   | start, busy, cmd     | transaction taken when start && !busy
//  result    | strobe, rsp          | one-cycle strobe per result, never stalled
//
// Walks: every walk goes through the registered RAM read port, one entry a
// cycle. Insert walks down from the top entry; a value that lands at the head
// is written in a closing state that stands in for the entry below the head.
// Search stops at a match; delete and list walk the whole table, and list
// gives one result a cycle. Full inserts and operations on an empty table
// answer in the cycle after they are taken, without raising busy.
// Reset clears the state and the entry count; RAM contents at or above the count are never read,
// so they need no clearing. Results cannot be held off.
module sorted_value_table_unit
    import svt_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic start,
    output logic busy,
    input  cmd_t cmd,
    output logic strobe,
    output rsp_t rsp
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_FIX
    } state_t;

    state_t state_reg, state_next;
    func_t  func_reg, func_next;
    logic signed [VAL_W-1:0] val_reg, val_next;
    cnt_t   count_reg, count_next;
    cnt_t   ptr_reg, ptr_next;        // next RAM address to read
    logic   issue_reg, issue_next;    // reads still to be issued
    logic   pv_reg, pv_next;          // RAM read data valid this cycle
    cnt_t   pidx_reg, pidx_next;      // index of that read data
    logic   found_reg, found_next;    // delete: match already seen
    logic   strobe_reg, strobe_next;
    rsp_t   rsp_reg, rsp_next;

    logic              ram_we;
    addr_t             ram_waddr;
    logic [VAL_W-1:0]  ram_wdata;
    addr_t             ram_raddr;
    logic [VAL_W-1:0]  ram_rdata;

    logic signed [VAL_W-1:0] rd_val;
    cnt_t last_idx;
    cnt_t pidx_up;
    cnt_t pidx_dn;
    logic at_last;

    svt_ram #(
        .WIDTH (VAL_W),
        .DEPTH (CAPACITY)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign rd_val   = $signed(ram_rdata);
    assign last_idx = count_reg - cnt_t'(1);
    assign pidx_up  = pidx_reg + cnt_t'(1);
    assign pidx_dn  = pidx_reg - cnt_t'(1);
    assign at_last  = (pidx_reg == last_idx);

    assign busy   = (state_reg != ST_IDLE);
    assign strobe = strobe_reg;
    assign rsp    = rsp_reg;

    always_comb
    begin
        state_next  = state_reg;
        func_next   = func_reg;
        val_next    = val_reg;
        count_next  = count_reg;
        ptr_next    = ptr_reg;
        issue_next  = issue_reg;
        pv_next     = 1'b0;
        pidx_next   = pidx_reg;
        found_next  = found_reg;
        strobe_next = 1'b0;
        rsp_next    = rsp_reg;
        ram_we      = 1'b0;
        ram_waddr   = '0;
        ram_wdata   = val_reg;
        ram_raddr   = ptr_reg[ADDR_W-1:0];

        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    func_next          = cmd.func;
                    val_next           = cmd.value;
                    found_next         = 1'b0;
                    rsp_next.value_out = cmd.value;
                    rsp_next.last      = 1'b1;
                    rsp_next.occupancy = occ_t'(count_reg);
                    if (cmd.func == FUNC_INSERT)
                    begin
                        if (count_reg == cnt_t'(CAPACITY))
                        begin
                            strobe_next     = 1'b1;
                            rsp_next.status = STATUS_FULL;
                        end
                        else if (count_reg == '0)
                        begin
                            // empty table: store at the head right away
                            ram_we             = 1'b1;
                            ram_waddr          = '0;
                            ram_wdata          = cmd.value;
                            count_next         = cnt_t'(1);
                            strobe_next        = 1'b1;
                            rsp_next.status    = STATUS_DONE;
                            rsp_next.occupancy = occ_t'(1);
                        end
                        else
                        begin
                            // walk down from the top entry, shifting as we go
                            ptr_next   = last_idx;
                            issue_next = 1'b1;
                            state_next = ST_RUN;
                        end
                    end
                    else if (count_reg == '0)
                    begin
                        strobe_next = 1'b1;
                        if (cmd.func == FUNC_LIST)
                        begin
                            rsp_next.status    = STATUS_EMPTY;
                            rsp_next.value_out = '0;
                        end
                        else
                        begin
                            rsp_next.status = STATUS_NOT_FOUND;
                        end
                    end
                    else
                    begin
                        ptr_next   = '0;
                        issue_next = 1'b1;
                        state_next = ST_RUN;
                    end
                end
            end

            ST_RUN:
            begin
                // issue side: one read a cycle, up or down the table
                if (issue_reg)
                begin
                    pv_next   = 1'b1;
                    pidx_next = ptr_reg;
                    if (func_reg == FUNC_INSERT)
                    begin
                        if (ptr_reg == '0)
                            issue_next = 1'b0;
                        else
                            ptr_next = ptr_reg - cnt_t'(1);
                    end
                    else
                    begin
                        if (ptr_reg == last_idx)
                            issue_next = 1'b0;
                        else
                            ptr_next = ptr_reg + cnt_t'(1);
                    end
                end

                // process side: act on the entry that just came back
                if (pv_reg)
                begin
                    case (func_reg)
                        FUNC_INSERT:
                        begin
                            ram_we    = 1'b1;
                            ram_waddr = pidx_up[ADDR_W-1:0];
                            if (rd_val >= val_reg)
                            begin
                                // move this entry up one place
                                ram_wdata = ram_rdata;
                                if (pidx_reg == '0)
                                begin
                                    state_next = ST_FIX;
                                    issue_next = 1'b0;
                                    pv_next    = 1'b0;
                                end
                            end
                            else
                            begin
                                ram_wdata          = val_reg;
                                count_next         = count_reg + cnt_t'(1);
                                strobe_next        = 1'b1;
                                rsp_next.status    = STATUS_DONE;
                                rsp_next.occupancy = occ_t'(count_reg + cnt_t'(1));
                                state_next         = ST_IDLE;
                                issue_next         = 1'b0;
                                pv_next            = 1'b0;
                            end
                        end

                        FUNC_SEARCH:
                        begin
                            if (rd_val == val_reg || at_last)
                            begin
                                strobe_next     = 1'b1;
                                rsp_next.status = (rd_val == val_reg) ?
                                                  STATUS_DONE : STATUS_NOT_FOUND;
                                state_next      = ST_IDLE;
                                issue_next      = 1'b0;
                                pv_next         = 1'b0;
                            end
                        end

                        FUNC_DELETE:
                        begin
                            if (found_reg)
                            begin
                                // close the gap left by the removed entry
                                ram_we    = 1'b1;
                                ram_waddr = pidx_dn[ADDR_W-1:0];
                                ram_wdata = ram_rdata;
                            end
                            else if (rd_val == val_reg)
                            begin
                                found_next = 1'b1;
                            end
                            if (at_last)
                            begin
                                strobe_next = 1'b1;
                                state_next  = ST_IDLE;
                                issue_next  = 1'b0;
                                pv_next     = 1'b0;
                                if (found_reg || rd_val == val_reg)
                                begin
                                    count_next         = last_idx;
                                    rsp_next.status    = STATUS_DONE;
                                    rsp_next.occupancy = occ_t'(last_idx);
                                end
                                else
                                begin
                                    rsp_next.status = STATUS_NOT_FOUND;
                                end
                            end
                        end

                        FUNC_LIST:
                        begin
                            strobe_next        = 1'b1;
                            rsp_next.status    = STATUS_DONE;
                            rsp_next.value_out = rd_val;
                            rsp_next.last      = at_last;
                            if (at_last)
                            begin
                                state_next = ST_IDLE;
                                issue_next = 1'b0;
                                pv_next    = 1'b0;
                            end
                        end

                        default:
                        begin
                            state_next = ST_IDLE;
                            issue_next = 1'b0;
                            pv_next    = 1'b0;
                        end
                    endcase
                end
            end

            ST_FIX:
            begin
                // the new value goes to the head
                ram_we             = 1'b1;
                ram_waddr          = '0;
                ram_wdata          = val_reg;
                count_next         = count_reg + cnt_t'(1);
                strobe_next        = 1'b1;
                rsp_next.status    = STATUS_DONE;
                rsp_next.occupancy = occ_t'(count_reg + cnt_t'(1));
                state_next         = ST_IDLE;
            end

            default:
            begin
                state_next = ST_IDLE;
                issue_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            func_reg   <= FUNC_INSERT;
            val_reg    <= '0;
            count_reg  <= '0;
            ptr_reg    <= '0;
            issue_reg  <= 1'b0;
            pv_reg     <= 1'b0;
            pidx_reg   <= '0;
            found_reg  <= 1'b0;
            strobe_reg <= 1'b0;
            rsp_reg    <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            func_reg   <= func_next;
            val_reg    <= val_next;
            count_reg  <= count_next;
            ptr_reg    <= ptr_next;
            issue_reg  <= issue_next;
            pv_reg     <= pv_next;
            pidx_reg   <= pidx_next;
            found_reg  <= found_next;
            strobe_reg <= strobe_next;
            rsp_reg    <= rsp_next;
        end
    end

endmodule
